### rtl/bic_pkg.sv
// Shared types, codes and field positions for the bootloader identity classifier.
`timescale 1ns / 1ps

package bic_pkg;

  // Verdict codes
  localparam logic [2:0] VERDICT_CLASSIC      = 3'd0;
  localparam logic [2:0] VERDICT_WRONG_MCU    = 3'd1;
  localparam logic [2:0] VERDICT_NO_READ      = 3'd2;
  localparam logic [2:0] VERDICT_NO_ERASE     = 3'd3;
  localparam logic [2:0] VERDICT_UNREAD       = 3'd4;
  localparam logic [2:0] VERDICT_UNRECOGNIZED = 3'd5;
  localparam logic [2:0] VERDICT_HW_BOOT      = 3'd6;
  localparam logic [2:0] VERDICT_VEC_BOOT     = 3'd7;

  // Configuration register indexes
  localparam logic CFG_EXPECTED_MCU_ID = 1'b0;
  localparam logic CFG_FLASH_BYTES     = 1'b1;

  // Reset values of the configuration registers
  localparam logic [10:0] EXPECTED_MCU_ID_RST = 11'd119;
  localparam logic [16:0] FLASH_BYTES_RST     = 17'd32768;

  // Default page size of the target
  localparam int PAGE_BYTES_DEF = 128;

  // Table acceptance limits
  localparam logic [7:0]  VER_MIN      = 8'o75;
  localparam logic [7:0]  VER_MAX      = 8'o147;
  localparam logic [7:0]  VER_CAP_MAX  = 8'o77;
  localparam logic [15:0] JUMP_RET     = 16'h9508;
  localparam logic [3:0]  JUMP_RJMP_HI = 4'hC;
  localparam logic [16:0] BOOT_MIN     = 17'd64;
  localparam logic [16:0] BOOT_MAX     = 17'd2048;
  localparam logic [7:0]  CAP_VEC_MASK = 8'h0C;

  // Sync reply values
  localparam logic [7:0]  SYNC_CLASSIC_A = 8'h14;
  localparam logic [7:0]  SYNC_CLASSIC_B = 8'h10;
  localparam logic [7:0]  SYNC_ALIAS_A   = 8'd255;
  localparam logic [7:0]  SYNC_ALIAS_B   = 8'd254;
  localparam logic [10:0] MCU_MOD        = 11'd2040;

  // Result item layout in out_tdata, lowest bit first
  localparam int OUT_VERDICT_LO = 0;
  localparam int OUT_MCU_LO     = 3;
  localparam int OUT_FEAT_LO    = 14;
  localparam int OUT_VMAJ_LO    = 19;
  localparam int OUT_VMIN_LO    = 24;
  localparam int OUT_BOOT_LO    = 27;
  localparam int OUT_APP_LO     = 41;
  localparam int OUT_VNUM_LO    = 58;
  localparam int OUT_COMPAT_LO  = 65;
  localparam int OUT_DATA_W     = 72;

  // One classified result item
  typedef struct packed {
    logic        is_compatible;
    logic [6:0]  vector_number;
    logic [16:0] app_bytes;
    logic [13:0] boot_bytes;
    logic [2:0]  version_minor;
    logic [4:0]  version_major;
    logic [4:0]  feature_bits;
    logic [10:0] mcu_id;
    logic [2:0]  verdict;
  } result_t;

endpackage

### rtl/bootloader_identity_classifier.sv
// Top level: classifies a serial bootloader from its sync reply and information table.
`timescale 1ns / 1ps

// Takes one item per cycle while the output is not stalled and returns one verdict item per
// input item: one register stage holds the accepted item and one holds the result, with the
// whole classification in the short logic between them. The sync pair is folded into a number
// whose value mod 2040 and div 2040 are found by splitting the first byte into its high five
// and low three bits, so no divider is used. A stalled result holds the pipe; the input stage
// still fills only while it is empty. The user is to write the expected MCU id and flash size
// through the cfg_ port while no item is in flight; the block itself does not enforce this.
module bootloader_identity_classifier
  import bic_pkg::*;
#(
  parameter int PAGE_BYTES = PAGE_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input items
  input  logic        in_tvalid,
  output logic        in_tready,
  // [7:0] sync_first, [15:8] sync_second, [23:16] pages_byte, [31:24] vector_byte,
  // [47:32] jump_word, [55:48] capability_byte, [63:56] version_byte
  input  logic [63:0] in_tdata,
  // [0] table_valid
  input  logic        in_tuser,
  // Result items
  output logic        out_tvalid,
  input  logic        out_tready,
  // [2:0] verdict, [13:3] mcu_id, [18:14] feature_bits, [23:19] version_major,
  // [26:24] version_minor, [40:27] boot_bytes, [57:41] app_bytes, [64:58] vector_number,
  // [65] is_compatible, [71:66] zero
  output logic [OUT_DATA_W-1:0] out_tdata,
  // Configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [16:0] cfg_data
);

  localparam int PagesMax = 127;
  localparam int BootW    = $clog2(PagesMax * PAGE_BYTES + 1);

  // Configuration registers
  logic [10:0] expected_mcu_id_r;
  logic [16:0] flash_bytes_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expected_mcu_id_r <= EXPECTED_MCU_ID_RST;
      flash_bytes_r     <= FLASH_BYTES_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_EXPECTED_MCU_ID: expected_mcu_id_r <= cfg_data[10:0];
        CFG_FLASH_BYTES:     flash_bytes_r     <= cfg_data;
        default:             ;
      endcase
    end
  end

  // Pipeline control
  logic s1_valid_r;
  logic out_valid_r;
  logic s1_advance;
  logic in_accept;

  assign s1_advance = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready  = !s1_valid_r || s1_advance;
  assign in_accept  = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) s1_valid_r <= in_tvalid;
      if (s1_advance) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  // Input stage
  logic [63:0] s1_data_r;
  logic        s1_table_valid_r;

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_data_r        <= in_tdata;
      s1_table_valid_r <= in_tuser;
    end
  end

  // Unpacked fields of the held item
  logic [7:0]  first, second, ver, cap;
  logic [6:0]  pages, vec;
  logic [15:0] jump;

  assign first  = s1_data_r[7:0];
  assign second = s1_data_r[15:8];
  assign pages  = s1_data_r[22:16];
  assign vec    = s1_data_r[30:24];
  assign jump   = s1_data_r[47:32];
  assign cap    = s1_data_r[55:48];
  assign ver    = s1_data_r[63:56];

  // Sync pair folding: num = a*255 + b, a = 8q + r, so num = 2040q + (255r + b)
  logic        is_classic;
  logic [7:0]  a_fold, b_fold;
  logic [10:0] low_part;
  logic        wrap;
  logic [10:0] mcu;
  logic [5:0]  feat;

  assign is_classic = (first == SYNC_CLASSIC_A) && (second == SYNC_CLASSIC_B);

  always_comb begin
    a_fold = first;
    b_fold = second;
    if (first == SYNC_ALIAS_A && second == SYNC_ALIAS_B) begin
      a_fold = SYNC_CLASSIC_A;
      b_fold = SYNC_CLASSIC_B;
    end else if (second > first) begin
      b_fold = second - 8'd1;
    end
  end

  // 255r = 256r - r; low part reaches 2040 only for r = 7, b = 255
  assign low_part = {a_fold[2:0], 8'd0} - {8'd0, a_fold[2:0]} + {3'd0, b_fold};
  assign wrap     = (low_part >= MCU_MOD);
  assign mcu      = wrap ? (low_part - MCU_MOD) : low_part;
  assign feat     = {1'b0, a_fold[7:3]} + {5'd0, wrap};

  // Table checks
  logic [BootW-1:0] boot_full;
  logic [16:0]      boot_ext;
  logic             form_ok;
  logic             size_ok;
  logic             vboot;
  logic [16:0]      app;

  assign boot_full = BootW'(pages) * BootW'(PAGE_BYTES);
  assign boot_ext  = 17'(boot_full);
  assign form_ok   = (ver >= VER_MIN) && (ver <= VER_MAX) &&
                     ((jump == JUMP_RET) || (jump[15:12] == JUMP_RJMP_HI));
  assign size_ok   = (boot_ext >= BOOT_MIN) && (boot_ext <= BOOT_MAX);
  assign vboot     = (vec != 7'd0) || ((ver <= VER_CAP_MAX) && ((cap & CAP_VEC_MASK) != 8'd0));
  assign app       = (flash_bytes_r >= boot_ext) ? (flash_bytes_r - boot_ext) : 17'd0;

  // Verdict and result fields
  result_t res;

  always_comb begin
    res = '0;
    if (!is_classic) begin
      res.mcu_id       = mcu;
      res.feature_bits = feat[4:0];
      if (mcu != expected_mcu_id_r) begin
        res.verdict = VERDICT_WRONG_MCU;
      end else if (!feat[2]) begin
        res.verdict = VERDICT_NO_READ;
      end else if (feat[3]) begin
        res.verdict = VERDICT_NO_ERASE;
      end else if (!s1_table_valid_r) begin
        res.verdict = VERDICT_UNREAD;
      end else begin
        res.version_major = ver[7:3];
        res.version_minor = ver[2:0];
        res.boot_bytes    = boot_ext[13:0];
        if (!form_ok || !size_ok) begin
          res.verdict = VERDICT_UNRECOGNIZED;
        end else begin
          res.verdict       = vboot ? VERDICT_VEC_BOOT : VERDICT_HW_BOOT;
          res.is_compatible = 1'b1;
          res.app_bytes     = app;
          res.vector_number = vboot ? vec : 7'd0;
        end
      end
    end
  end

  // Result register
  result_t out_res_r;

  always_ff @(posedge clk) begin
    if (s1_advance) out_res_r <= res;
  end

  assign out_tdata = {{(OUT_DATA_W - $bits(result_t)){1'b0}}, out_res_r};

endmodule

### rtl/bic_checker.sv
// Port-level checker for the bootloader identity classifier and its bind.
`timescale 1ns / 1ps

module bic_checker
  import bic_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata
);

  logic [2:0]  verdict;
  logic [10:0] mcu_id;
  logic [4:0]  feature_bits;
  logic [16:0] app_bytes;
  logic        is_compatible;

  assign verdict       = out_tdata[OUT_VERDICT_LO +: 3];
  assign mcu_id        = out_tdata[OUT_MCU_LO +: 11];
  assign feature_bits  = out_tdata[OUT_FEAT_LO +: 5];
  assign app_bytes     = out_tdata[OUT_APP_LO +: 17];
  assign is_compatible = out_tdata[OUT_COMPAT_LO];

  // A stalled result item holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result item changed while stalled");

  // No result item right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result item valid after reset");

  // Compatible flag follows the verdict
  a_compat: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> is_compatible ==
      ((verdict == VERDICT_HW_BOOT) || (verdict == VERDICT_VEC_BOOT)))
    else $error("compatible flag disagrees with verdict");

  // Classic reply carries no decoded id; app space only for accepted bootloaders
  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !is_compatible |-> app_bytes == 17'd0 &&
      (verdict != VERDICT_CLASSIC || (mcu_id == 11'd0 && feature_bits == 5'd0)))
    else $error("unused result fields not cleared");

endmodule

bind bootloader_identity_classifier bic_checker u_bic_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
